FILE: rtl/rxq_pkg.sv
// Package: payload types, register indexes and quantizer thresholds for the xterm-256 quantizer
`default_nettype none

package rxq_pkg;

    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int CUBE_W     = 3;
    localparam int LUM_W      = 5;
    localparam int SUM_W      = 10;
    localparam int BIAS_W     = 18;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 1;
    localparam int NUM_CUBE_THR = 5;
    localparam int NUM_LUM_THR  = 23;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAD_OFFSET = 1'b0,
        CFG_GRAY_BIAS  = 1'b1
    } t_cfg_idx;

    // Channel value at which round(c/51) steps to the next level.
    localparam logic [CHAN_W-1:0] CUBE_THR [NUM_CUBE_THR] = '{
        8'd26, 8'd77, 8'd128, 8'd179, 8'd230
    };

    // Channel sum at which round(sum*23/765) steps to the next level.
    localparam logic [SUM_W-1:0] LUM_THR [NUM_LUM_THR] = '{
        10'd17,  10'd50,  10'd84,  10'd117, 10'd150, 10'd183,
        10'd217, 10'd250, 10'd283, 10'd316, 10'd350, 10'd383,
        10'd416, 10'd450, 10'd483, 10'd516, 10'd549, 10'd583,
        10'd616, 10'd649, 10'd682, 10'd716, 10'd749
    };

    localparam logic [7:0] CUBE_BASE = 8'd16;
    localparam logic [7:0] GRAY_BASE = 8'd232;
    localparam logic [7:0] CUBE_R_STEP = 8'd36;
    localparam logic [7:0] CUBE_G_STEP = 8'd6;
    localparam logic [LUM_W-1:0] LUM_NO_GRAY = 5'd1;

    // Error scale factors (all errors multiplied by 115)
    localparam logic [14:0] CHAN_SCALE = 15'd115;
    localparam logic [14:0] GRAY_SCALE = 15'd1275;
    localparam logic [14:0] CUBE_SCALE = 15'd5865;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0] color_index;
        logic       is_gray;
    } t_result;

    typedef struct packed {
        logic [NUM_CHAN-1:0][CHAN_W-1:0] ch;
        logic [NUM_CHAN-1:0][CUBE_W-1:0] q;
        logic [LUM_W-1:0]                lum;
    } t_levels;

endpackage

`default_nettype wire

FILE: rtl/rxq_level.sv
// Padding, per-channel cube level and gray ramp level of one pixel
`default_nettype none

module rxq_level (
    input  rxq_pkg::t_pixel                 i_pixel,
    input  logic [rxq_pkg::CHAN_W-1:0]      i_pad_offset,
    output rxq_pkg::t_levels                o_levels
);

    logic [rxq_pkg::NUM_CHAN-1:0][rxq_pkg::CHAN_W-1:0] raw;
    logic [rxq_pkg::NUM_CHAN-1:0][rxq_pkg::CHAN_W-1:0] ch;
    logic [rxq_pkg::SUM_W-1:0]                         sum;
    logic [rxq_pkg::NUM_CHAN-1:0][rxq_pkg::NUM_CUBE_THR-1:0] cube_hit;
    logic [rxq_pkg::NUM_LUM_THR-1:0]                   lum_hit;

    always_comb begin
        raw[0] = i_pixel.red;
        raw[1] = i_pixel.green;
        raw[2] = i_pixel.blue;
        for (int i = 0; i < rxq_pkg::NUM_CHAN; i++) begin
            ch[i] = (raw[i] >= i_pad_offset) ? raw[i] - i_pad_offset : '0;
            for (int k = 0; k < rxq_pkg::NUM_CUBE_THR; k++) begin
                cube_hit[i][k] = (ch[i] >= rxq_pkg::CUBE_THR[k]);
            end
        end
        sum = rxq_pkg::SUM_W'(ch[0]) + rxq_pkg::SUM_W'(ch[1]) + rxq_pkg::SUM_W'(ch[2]);
        for (int k = 0; k < rxq_pkg::NUM_LUM_THR; k++) begin
            lum_hit[k] = (sum >= rxq_pkg::LUM_THR[k]);
        end

        o_levels.ch  = ch;
        for (int i = 0; i < rxq_pkg::NUM_CHAN; i++) begin
            o_levels.q[i] = rxq_pkg::CUBE_W'($countones(cube_hit[i]));
        end
        o_levels.lum = rxq_pkg::LUM_W'($countones(lum_hit));
    end

endmodule

`default_nettype wire

FILE: rtl/rxq_select.sv
// Cube and gray error sums and the final palette choice
`default_nettype none

module rxq_select (
    input  rxq_pkg::t_levels                    i_levels,
    input  logic signed [rxq_pkg::BIAS_W-1:0]   i_gray_bias,
    output rxq_pkg::t_result                    o_result
);

    logic [14:0] gray_val;
    logic [rxq_pkg::NUM_CHAN-1:0][14:0] chan_val;
    logic [rxq_pkg::NUM_CHAN-1:0][14:0] cube_val;
    logic [rxq_pkg::NUM_CHAN-1:0][14:0] gdiff;
    logic [rxq_pkg::NUM_CHAN-1:0][14:0] cdiff;
    logic [16:0] gerr;
    logic [16:0] cerr;
    logic signed [19:0] gray_lim;
    logic signed [19:0] cube_err_s;
    logic        pick_cube;
    logic [7:0]  cube_idx;

    always_comb begin
        gray_val = rxq_pkg::GRAY_SCALE * 15'(i_levels.lum);
        for (int i = 0; i < rxq_pkg::NUM_CHAN; i++) begin
            chan_val[i] = rxq_pkg::CHAN_SCALE * 15'(i_levels.ch[i]);
            cube_val[i] = rxq_pkg::CUBE_SCALE * 15'(i_levels.q[i]);
            gdiff[i] = (chan_val[i] > gray_val) ? chan_val[i] - gray_val
                                                : gray_val - chan_val[i];
            cdiff[i] = (chan_val[i] > cube_val[i]) ? chan_val[i] - cube_val[i]
                                                   : cube_val[i] - chan_val[i];
        end
        gerr = 17'(gdiff[0]) + 17'(gdiff[1]) + 17'(gdiff[2]);
        cerr = 17'(cdiff[0]) + 17'(cdiff[1]) + 17'(cdiff[2]);

        gray_lim   = $signed({3'b000, gerr}) - 20'(i_gray_bias);
        cube_err_s = $signed({3'b000, cerr});
        pick_cube  = (cube_err_s < gray_lim) || (i_levels.lum == rxq_pkg::LUM_NO_GRAY);

        cube_idx = rxq_pkg::CUBE_BASE
                 + rxq_pkg::CUBE_R_STEP * 8'(i_levels.q[0])
                 + rxq_pkg::CUBE_G_STEP * 8'(i_levels.q[1])
                 + 8'(i_levels.q[2]);

        o_result.color_index = pick_cube ? cube_idx
                                         : rxq_pkg::GRAY_BASE + 8'(i_levels.lum);
        o_result.is_gray     = !pick_cube;
    end

endmodule

`default_nettype wire

FILE: rtl/rgb_to_xterm256_quantizer.sv
// Top level: RGB pixel to xterm 256-color index, two-register pipeline
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_data  (red, green, blue)
//  out     | output    | o_out_valid / i_out_ready | o_out_data (color_index, is_gray)
//  cfg     | input     | i_cfg_wr_en               | i_cfg_idx, i_cfg_wdata
//
//  One pixel per cycle while the output is not stalled; each pixel is registered
//  in stage 1 and then in stage 2, whose register drives the output.
//  Stage 1 registers the padded channels and their levels, stage 2 the result.
//  A stalled output holds stage 2 and a full stage 1; an empty stage 1 still fills while stage 2 waits.
//  Synchronous active-low reset clears valids and both config registers.
`default_nettype none

module rgb_to_xterm256_quantizer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  rxq_pkg::t_pixel                    i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output rxq_pkg::t_result                   o_out_data,
    input  logic                               i_cfg_wr_en,
    input  logic [rxq_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rxq_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    logic [rxq_pkg::CHAN_W-1:0]          r_pad_offset;
    logic signed [rxq_pkg::BIAS_W-1:0]   r_gray_bias;

    logic                r_s1_vld;
    rxq_pkg::t_levels    r_lvl;
    logic                r_out_vld;
    rxq_pkg::t_result    r_out;

    rxq_pkg::t_levels    n_lvl;
    rxq_pkg::t_result    n_out;
    logic                s2_ready;
    logic                s1_ready;

    rxq_level u_level (
        .i_pixel      (i_in_data),
        .i_pad_offset (r_pad_offset),
        .o_levels     (n_lvl)
    );

    rxq_select u_select (
        .i_levels    (r_lvl),
        .i_gray_bias (r_gray_bias),
        .o_result    (n_out)
    );

    assign s2_ready = !r_out_vld || i_out_ready;
    assign s1_ready = !r_s1_vld || s2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_offset <= '0;
            r_gray_bias  <= '0;
        end else if (i_cfg_wr_en) begin
            case (rxq_pkg::t_cfg_idx'(i_cfg_idx))
                rxq_pkg::CFG_PAD_OFFSET: r_pad_offset <= i_cfg_wdata[rxq_pkg::CHAN_W-1:0];
                rxq_pkg::CFG_GRAY_BIAS:  r_gray_bias  <= $signed(i_cfg_wdata[rxq_pkg::BIAS_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_vld <= i_in_valid;
            end
            if (s2_ready) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_lvl <= n_lvl;
        end
        if (s2_ready && r_s1_vld) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = s1_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_gray_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.is_gray == (o_out_data.color_index >= rxq_pkg::GRAY_BASE)))
        else $error("is_gray disagrees with color_index range");

    a_cube_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.color_index >= rxq_pkg::CUBE_BASE))
        else $error("color_index below palette base");

    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_s1_vld)
        else $error("input transfer lost before stage 1");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_out_vld && !i_out_ready) |=> (r_s1_vld && $stable(r_lvl)))
        else $error("stage 1 changed while output stalled");

endmodule

`default_nettype wire
